/* rtl/fms_pkg.sv */
`timescale 1ns / 1ps
package fms_pkg;
  localparam int POINTS_DEF = 128;
  localparam int MAX_PTS    = 128;
  localparam int DW         = 24;
  localparam int TW         = 16;
  localparam int SAMPLE_W   = 8;
  localparam int LEVEL_W    = 10;
  localparam int BIN_W      = 6;

  typedef logic signed [DW-1:0] data_t;

  // Quarter-wave sine table, Q1.15, 33 entries.
  function automatic logic signed [TW-1:0] qwave(input logic [5:0] k);
    logic signed [TW-1:0] v;
    case (k)
      6'd0: v = 16'sd0;      6'd1: v = 16'sd1608;   6'd2: v = 16'sd3212;
      6'd3: v = 16'sd4808;   6'd4: v = 16'sd6393;   6'd5: v = 16'sd7962;
      6'd6: v = 16'sd9512;   6'd7: v = 16'sd11039;  6'd8: v = 16'sd12540;
      6'd9: v = 16'sd14010;  6'd10: v = 16'sd15447; 6'd11: v = 16'sd16846;
      6'd12: v = 16'sd18205; 6'd13: v = 16'sd19520; 6'd14: v = 16'sd20788;
      6'd15: v = 16'sd22006; 6'd16: v = 16'sd23170; 6'd17: v = 16'sd24279;
      6'd18: v = 16'sd25330; 6'd19: v = 16'sd26320; 6'd20: v = 16'sd27246;
      6'd21: v = 16'sd28106; 6'd22: v = 16'sd28899; 6'd23: v = 16'sd29622;
      6'd24: v = 16'sd30274; 6'd25: v = 16'sd30853; 6'd26: v = 16'sd31357;
      6'd27: v = 16'sd31786; 6'd28: v = 16'sd32138; 6'd29: v = 16'sd32413;
      6'd30: v = 16'sd32610; 6'd31: v = 16'sd32729; 6'd32: v = 16'sd32767;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sin(2*pi*i/128) for i in 0..63 (first half wave of a 128-point table).
  function automatic logic signed [TW-1:0] sine_rom(input logic [5:0] k);
    logic [5:0] m;
    m = 6'd0 - k;
    return (k <= 6'd32) ? qwave(k) : qwave(m);
  endfunction
endpackage

/* rtl/fms_if.sv */
`timescale 1ns / 1ps
interface fms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fms_out_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] level;
  logic [5:0]        bin;
  logic              last;
  modport source (output valid, output level, output bin, output last, input ready);
  modport sink (input valid, input level, input bin, input last, output ready);
endinterface

/* rtl/fft_magnitude_spectrum.sv */
`timescale 1ns / 1ps
// Magnitude spectrum of blocks of POINTS unsigned 8-bit samples.
// Input channel: one sample per transfer; samples pass through a two-entry
// queue into a working store at bit-reversed addresses.
// After the last sample of a block, a single butterfly unit runs the
// radix-2 FFT (POINTS/2*log2(POINTS) butterflies), then each of the
// POINTS/2 bins goes through a store read, squared sum, a 24-step square
// root and scaling.
// Output channel: POINTS/2 transfers of level, bin and last (last on the
// final bin). A finished level waits in the output register while the next
// bin is computed; a stalled receiver holds the sequence.
// While a block is processed, new samples fill the queue and then wait.
// Reset (rst_n low, synchronous) empties the queue, zeroes the sample count
// and returns the sequencer to filling.
module fft_magnitude_spectrum #(
  parameter int POINTS = fms_pkg::POINTS_DEF
) (
  input logic clk,
  input logic rst_n,
  fms_in_if.sink    in_ch,
  fms_out_if.source out_ch
);
  import fms_pkg::*;
  logic q_valid, q_ready, q_last;
  logic [$clog2(POINTS)-1:0] q_addr;
  logic signed [8:0] q_data;

  fms_front #(.POINTS(POINTS)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_ready, .q_addr, .q_data, .q_last
  );
  fms_back #(.POINTS(POINTS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_addr, .q_data, .q_last, .out_ch
  );
endmodule

/* rtl/fms_front.sv */
`timescale 1ns / 1ps
// Accepts samples, counts the block and queues them with their bit-reversed address.
module fms_front #(
  parameter int POINTS = fms_pkg::POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fms_in_if.sink in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output logic [$clog2(POINTS)-1:0] q_addr,
  output logic signed [8:0]         q_data,
  output logic                      q_last
);
  import fms_pkg::*;
  localparam int LB = $clog2(POINTS);
  localparam int QD = 2;

  logic [LB-1:0] cnt_r;
  logic [LB-1:0] qa_r [QD];
  logic [8:0]    qd_r [QD];
  logic          ql_r [QD];
  logic          wp_r, rp_r;
  logic [1:0]    fill_r;
  logic [LB-1:0] rev;
  logic          push, pop;

  always_comb begin
    for (int b = 0; b < LB; b++) rev[b] = cnt_r[LB-1-b];
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (fill_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_addr = qa_r[rp_r];
  assign q_data = qd_r[rp_r];
  assign q_last = ql_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      qa_r[wp_r] <= rev;
      qd_r[wp_r] <= {1'b0, in_ch.sample} - 9'd128;
      ql_r[wp_r] <= (cnt_r == LB'(POINTS - 1));
    end
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= 2'd0;
    end else begin
      if (push) begin
        cnt_r <= cnt_r + 1'b1;
        wp_r  <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/fms_back.sv */
`timescale 1ns / 1ps
// Stores samples, runs the FFT with one butterfly unit, then computes levels.
module fms_back #(
  parameter int POINTS = fms_pkg::POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  logic [$clog2(POINTS)-1:0] q_addr,
  input  logic signed [8:0]         q_data,
  input  logic                      q_last,
  fms_out_if.source out_ch
);
  import fms_pkg::*;
  localparam int LB = $clog2(POINTS);
  localparam int HB = LB - 1;
  localparam int TSH = $clog2(MAX_PTS / POINTS);

  localparam logic [3:0] S_FILL = 4'd0, S_RA = 4'd1, S_RB = 4'd2, S_M1 = 4'd3,
                         S_M2 = 4'd4, S_WA = 4'd5, S_WB = 4'd6, S_MR = 4'd7,
                         S_MW = 4'd8, S_SQ = 4'd9, S_OUT = 4'd10;

  logic [3:0] st_r;
  data_t mre [POINTS];
  data_t mim [POINTS];
  logic [LB-1:0] raddr;
  data_t rd_re_r, rd_im_r;

  logic [$clog2(LB+1)-1:0] stg_r;   // stage 0..LB-1
  logic [HB-1:0] bf_r;             // butterfly index within stage
  logic [HB-1:0] bin_r;
  data_t ar_r, ai_r, br_r, bi_r;
  logic signed [TW-1:0] wr_r, wi_r;
  logic signed [DW+TW:0] p1_r, p2_r, p3_r, p4_r;
  data_t na_re_r, na_im_r, nb_re_r, nb_im_r;
  logic [47:0] acc_r;
  logic [47:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  it_r;

  // butterfly addresses
  logic [LB-1:0] half, jj, grp, a_addr, b_addr, mask;
  logic [HB-1:0] tw;
  always_comb begin
    half = LB'(1) << stg_r;
    mask = half - 1'b1;
    jj   = {1'b0, bf_r} & mask;
    grp  = ({1'b0, bf_r} >> stg_r) << (stg_r + 1);
    a_addr = grp | jj;
    b_addr = a_addr | half;
    tw = HB'(({1'b0, jj} << (LB - 1 - stg_r)));
  end

  logic [5:0] t_idx, c_idx;
  logic signed [TW-1:0] tsin, tcos;
  always_comb begin
    t_idx = 6'(tw) << TSH;
    c_idx = t_idx + 6'd32;
    tsin = sine_rom(t_idx);
    tcos = (t_idx < 6'd32) ? sine_rom(c_idx) : -sine_rom(t_idx - 6'd32);
  end

  function automatic data_t sat(input logic signed [DW+1:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[DW-1:0];
  endfunction

  // rounded twiddle products stay unsaturated until the butterfly sums
  logic signed [DW+TW+1:0] tr_s, ti_s;
  logic signed [DW+1:0] tr, ti;
  always_comb begin
    // w = cos - j sin -> wi = -sin
    tr_s = (DW+TW+2)'(p1_r) - (DW+TW+2)'(p2_r) + (DW+TW+2)'(16384);
    ti_s = (DW+TW+2)'(p3_r) + (DW+TW+2)'(p4_r) + (DW+TW+2)'(16384);
    tr = 26'(tr_s >>> 15);
    ti = 26'(ti_s >>> 15);
  end

  always_comb begin
    unique case (st_r)
      S_RB:    raddr = b_addr;
      S_MR:    raddr = LB'(bin_r);
      default: raddr = a_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_re_r <= mre[raddr];
    rd_im_r <= mim[raddr];
    if (st_r == S_FILL && q_valid) begin
      mre[q_addr] <= DW'(q_data);
      mim[q_addr] <= '0;
    end else if (st_r == S_WA) begin
      mre[a_addr] <= na_re_r;
      mim[a_addr] <= na_im_r;
    end else if (st_r == S_WB) begin
      mre[b_addr] <= nb_re_r;
      mim[b_addr] <= nb_im_r;
    end
  end

  assign q_ready = (st_r == S_FILL);

  // isqrt: restoring, two bits of radicand per step
  logic [49:0] trial;
  logic [47:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[45:0], acc_r[47:46]};
    trial = {2'b0, rem_sh} - {24'd0, root_r, 2'b01};
  end

  logic [23:0] mag;
  logic [26:0] num;
  logic signed [27:0] lvl_full;
  logic signed [LEVEL_W-1:0] lvl;
  always_comb begin
    mag = root_r;
    num = (bin_r == '0) ? {2'b0, mag, 1'b0} : {1'b0, mag, 2'b0};
    lvl_full = 28'sd128 - 28'(num >> LB);
    // truncation toward zero: quotient rounds up while 128 - num/n is positive
    if ((num >> LB) < 27'd128 && (num & 27'((1 << LB) - 1)) != 27'd0)
      lvl_full = lvl_full - 28'sd1;
    lvl = (lvl_full < -28'sd384) ? -10'sd384 : LEVEL_W'(lvl_full);
  end

  logic signed [DW+TW:0] m1, m2, m3, m4;
  always_comb begin
    m1 = br_r * wr_r;
    m2 = bi_r * wi_r;
    m3 = br_r * wi_r;
    m4 = bi_r * wr_r;
  end

  logic out_busy_r;
  assign out_ch.valid = out_busy_r;

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_RB: begin
        wr_r <= tcos;
        wi_r <= -tsin;
        ar_r <= rd_re_r; ai_r <= rd_im_r;
      end
      S_M1: begin br_r <= rd_re_r; bi_r <= rd_im_r; end
      S_WA: begin
        p1_r <= m1; p2_r <= m2; p3_r <= m3; p4_r <= m4;
      end
      S_MW: begin
        acc_r <= 48'(rd_re_r * rd_re_r) + 48'(rd_im_r * rd_im_r);
        rem_r <= '0; root_r <= '0;
      end
      S_SQ: begin
        acc_r <= acc_r << 2;
        if (!trial[49]) begin
          rem_r <= trial[47:0];
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root_r <= {root_r[22:0], 1'b0};
        end
      end
      S_OUT: if (!out_busy_r) begin
        out_ch.level <= lvl;
        out_ch.bin <= BIN_W'(bin_r);
        out_ch.last <= (bin_r == HB'(POINTS / 2 - 1));
      end
      default: ;
    endcase
    if (st_r == S_WB) begin
      na_re_r <= sat(26'(ar_r) + tr);
      na_im_r <= sat(26'(ai_r) + ti);
      nb_re_r <= sat(26'(ar_r) - tr);
      nb_im_r <= sat(26'(ai_r) - ti);
    end
  end

  // Sequencing: RA->RB->M1->M2->WA(products)->WB(sums)->... writes trail by one state.
  logic [1:0] wph_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_FILL; stg_r <= '0; bf_r <= '0; bin_r <= '0;
      it_r <= '0; out_busy_r <= 1'b0; wph_r <= '0;
    end else begin
      if (out_busy_r && out_ch.ready) out_busy_r <= 1'b0;
      unique case (st_r)
        S_FILL: if (q_valid && q_last) st_r <= S_RA;
        S_RA:   st_r <= S_RB;
        S_RB:   st_r <= S_M1;
        S_M1:   st_r <= S_M2;
        S_M2:   begin st_r <= S_WA; wph_r <= 2'd0; end
        S_WA: begin
          // first visit: products; second: write a
          if (wph_r == 2'd0) begin wph_r <= 2'd1; st_r <= S_WB; end
          else st_r <= S_WB;
        end
        S_WB: begin
          if (wph_r == 2'd1) begin wph_r <= 2'd2; st_r <= S_WA; end
          else begin
            if (bf_r == HB'(POINTS / 2 - 1)) begin
              bf_r <= '0;
              if (stg_r == ($bits(stg_r))'(LB - 1)) begin
                stg_r <= '0; bin_r <= '0; st_r <= S_MR;
              end else begin
                stg_r <= stg_r + 1'b1; st_r <= S_RA;
              end
            end else begin
              bf_r <= bf_r + 1'b1; st_r <= S_RA;
            end
          end
        end
        S_MR: st_r <= S_MW;
        S_MW: begin it_r <= '0; st_r <= S_SQ; end
        S_SQ: begin
          it_r <= it_r + 1'b1;
          if (it_r == 5'd23) st_r <= S_OUT;
        end
        S_OUT: if (!out_busy_r) begin
          out_busy_r <= 1'b1;
          if (bin_r == HB'(POINTS / 2 - 1)) st_r <= S_FILL;
          else begin bin_r <= bin_r + 1'b1; st_r <= S_MR; end
        end
        default: st_r <= S_FILL;
      endcase
    end
  end
endmodule
